@@ hw/rtl/cprt_pkg.sv @@
`timescale 1ns / 1ps

package cprt_pkg;

	localparam int COUNT_BITS = 16;
	// counter is zero-extended to this width for byte access
	localparam int WIDE_BITS = 32;
	localparam int PHASE_W = 10;
	localparam int CTS_W = 11;
	// longest wait: largest period plus the start delay
	localparam logic [CTS_W-1:0] CTS_MAX = 11'd1026;
	localparam logic [CTS_W-1:0] START_DELAY = 11'd2;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	localparam logic [1:0] SEL_LOW  = 2'd0;
	localparam logic [1:0] SEL_HIGH = 2'd1;
	localparam logic [1:0] SEL_CTRL = 2'd2;

	localparam logic [1:0] PS_DIV1    = 2'd0;
	localparam logic [1:0] PS_DIV64   = 2'd1;
	localparam logic [1:0] PS_DIV256  = 2'd2;
	localparam logic [1:0] PS_DIV1024 = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] reg_sel;
		logic [7:0] wdata;
		logic       chain_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       overflow_out;
		logic       irq;
	} out_item_t;

	function automatic logic [CTS_W-1:0] prescale_period(input logic [1:0] ps);
		logic [CTS_W-1:0] p;
		case (ps)
			PS_DIV1:    p = 11'd1;
			PS_DIV64:   p = 11'd64;
			PS_DIV256:  p = 11'd256;
			PS_DIV1024: p = 11'd1024;
			default:    p = 11'd1;
		endcase
		return p;
	endfunction

	function automatic logic [PHASE_W-1:0] prescale_mask(input logic [1:0] ps);
		logic [PHASE_W-1:0] m;
		case (ps)
			PS_DIV1:    m = 10'h000;
			PS_DIV64:   m = 10'h03F;
			PS_DIV256:  m = 10'h0FF;
			PS_DIV1024: m = 10'h3FF;
			default:    m = 10'h000;
		endcase
		return m;
	endfunction

endpackage

@@ hw/rtl/cprt_core.sv @@
`timescale 1ns / 1ps

module cprt_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  cprt_pkg::in_item_t   item,
	input  logic [1:0]           timer_index,
	output cprt_pkg::out_item_t  result
);

	localparam int CNT_W = cprt_pkg::COUNT_BITS;

	logic [CNT_W-1:0]             count_q, count_d;
	logic [CNT_W-1:0]             reload_q, reload_d;
	logic                         run_q, run_d;
	logic                         irq_en_q, irq_en_d;
	logic                         casc_q, casc_d;
	logic [1:0]                   ps_q, ps_d;
	logic [cprt_pkg::CTS_W-1:0]   cts_q, cts_d;
	logic [cprt_pkg::PHASE_W-1:0] phase_q, phase_d;

	logic [CNT_W-1:0]               count_inc;
	logic [CNT_W-1:0]               count_bumped;
	logic                           wrap;
	logic                           wrapped;
	logic [cprt_pkg::WIDE_BITS-1:0] count_wide;
	logic [cprt_pkg::WIDE_BITS-1:0] reload_wide;
	logic [7:0]                     rdata;

	assign count_inc    = count_q + CNT_W'(1);
	assign wrap         = (count_inc == '0);
	assign count_bumped = wrap ? reload_q : count_inc;
	assign count_wide   = cprt_pkg::WIDE_BITS'(count_q);

	always_comb begin
		count_d     = count_q;
		reload_d    = reload_q;
		run_d       = run_q;
		irq_en_d    = irq_en_q;
		casc_d      = casc_q;
		ps_d        = ps_q;
		cts_d       = cts_q;
		phase_d     = phase_q;
		wrapped     = 1'b0;
		rdata       = 8'h00;
		reload_wide = cprt_pkg::WIDE_BITS'(reload_q);
		case (item.op)
			cprt_pkg::OP_TICK: begin
				phase_d = phase_q + 10'd1;
				if (run_q) begin
					if (casc_q) begin
						if (item.chain_in) begin
							count_d = count_bumped;
							wrapped = wrap;
						end
					end else if (cts_q > 11'd1) begin
						cts_d = cts_q - 11'd1;
					end else begin
						cts_d   = cprt_pkg::prescale_period(ps_q);
						count_d = count_bumped;
						wrapped = wrap;
					end
				end
			end
			cprt_pkg::OP_READ: begin
				case (item.reg_sel)
					cprt_pkg::SEL_LOW:  rdata = count_wide[7:0];
					cprt_pkg::SEL_HIGH: rdata = count_wide[15:8];
					cprt_pkg::SEL_CTRL: rdata = {run_q, irq_en_q, 3'b000, casc_q, ps_q};
					default:            rdata = 8'h00;
				endcase
			end
			cprt_pkg::OP_WRITE: begin
				case (item.reg_sel)
					cprt_pkg::SEL_LOW: begin
						reload_wide[7:0] = item.wdata;
						reload_d         = reload_wide[CNT_W-1:0];
					end
					cprt_pkg::SEL_HIGH: begin
						reload_wide[15:8] = item.wdata;
						reload_d          = reload_wide[CNT_W-1:0];
					end
					cprt_pkg::SEL_CTRL: begin
						run_d    = item.wdata[7];
						irq_en_d = item.wdata[6];
						casc_d   = (timer_index != 2'd0) && item.wdata[2];
						ps_d     = item.wdata[1:0];
						if (item.wdata[7]) begin
							if (!run_q)
								count_d = reload_q;
							// align the next step to the free-running phase
							if (!casc_d) begin
								cts_d = cprt_pkg::prescale_period(ps_d)
								      - {1'b0, phase_q & cprt_pkg::prescale_mask(ps_d)}
								      + (run_q ? 11'd0 : cprt_pkg::START_DELAY);
							end
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			reload_q <= '0;
			run_q    <= 1'b0;
			irq_en_q <= 1'b0;
			casc_q   <= 1'b0;
			ps_q     <= 2'd0;
			cts_q    <= '0;
			phase_q  <= '0;
		end else if (fire) begin
			count_q  <= count_d;
			reload_q <= reload_d;
			run_q    <= run_d;
			irq_en_q <= irq_en_d;
			casc_q   <= casc_d;
			ps_q     <= ps_d;
			cts_q    <= cts_d;
			phase_q  <= phase_d;
		end
	end

	assign result.rdata        = rdata;
	assign result.overflow_out = wrapped;
	assign result.irq          = wrapped & irq_en_q;

	a_cts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cts_q <= cprt_pkg::CTS_MAX)
		else $error("step countdown out of range");

	a_read_no_side_effect: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == cprt_pkg::OP_READ |=> $stable(count_q) && $stable(reload_q)
			&& $stable(run_q))
		else $error("register read changed timer state");

	a_stopped_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !run_q && item.op == cprt_pkg::OP_TICK |=> $stable(count_q))
		else $error("stopped timer counted");

	a_overflow_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.overflow_out |-> item.op == cprt_pkg::OP_TICK && run_q)
		else $error("overflow outside a running tick");

endmodule

@@ hw/rtl/cascadable_prescaled_reload_timer.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake            | word
// in      | input     | in_valid / in_ready   | in_data  (op, reg_sel, wdata, chain_in)
// out     | output    | out_valid / out_ready | out_data (rdata, overflow_out, irq)
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (timer_index)
//
// One word per cycle sustained while out_ready is high; out_valid rises as res_s2 loads.
// The input register feeds the timer state update, which writes the output register.
// Input stalls only when both registers are full and out_ready is low.
// cfg_ready is always high; arst_n clears the timer state and both valid flags.

module cascadable_prescaled_reload_timer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cprt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cprt_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_data
);

	cprt_pkg::in_item_t  item_s1;
	logic                valid_s1;
	cprt_pkg::out_item_t res_s2;
	logic                valid_s2;
	cprt_pkg::out_item_t core_res;
	logic [1:0]          timer_index_q;
	logic                advance;

	// stage 1 moves on when the output slot is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			timer_index_q <= 2'd0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
			if (cfg_valid)
				timer_index_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
		if (advance)
			res_s2 <= core_res;
	end

	cprt_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.item        (item_s1),
		.timer_index (timer_index_q),
		.result      (core_res)
	);

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

@@ verif/cascadable_prescaled_reload_timer_test.sv @@
`timescale 1ns / 1ps

import cprt_pkg::*;

// Shadow of the timer: tracks count, reload and control state and queues the
// word each input should produce.
class timer_mirror;
	logic [1:0]            chain_pos;
	logic [COUNT_BITS-1:0] count;
	logic [COUNT_BITS-1:0] reload;
	bit                    running;
	bit                    irq_en;
	bit                    cascade;
	logic [1:0]            ps;
	logic [CTS_W-1:0]      ticks_left;
	logic [PHASE_W-1:0]    phase;
	out_item_t             due_words[$];
	int                    mismatches;

	function new();
		chain_pos = '0;
		count = '0;
		reload = '0;
		running = 1'b0;
		irq_en = 1'b0;
		cascade = 1'b0;
		ps = PS_DIV1;
		ticks_left = '0;
		phase = '0;
		mismatches = 0;
	endfunction

	function logic [CTS_W-1:0] period(logic [1:0] sel);
		return (sel == PS_DIV1) ? CTS_W'(1) : CTS_W'(1) << (4 + 2 * sel);
	endfunction

	function bit count_up();
		count = count + 1'b1;
		if (count != '0)
			return 1'b0;
		count = reload;
		return 1'b1;
	endfunction

	function void write_control(logic [7:0] b);
		bit fresh;
		logic [CTS_W-1:0] p;
		fresh = !running;
		running = b[7];
		irq_en = b[6];
		cascade = (chain_pos != 2'd0) && b[2];
		ps = b[1:0];
		if (!running)
			return;
		if (fresh)
			count = reload;
		if (!cascade) begin
			// align the first step to the free-running phase
			p = period(ps);
			ticks_left = p - CTS_W'(phase & PHASE_W'(p - 1'b1));
			if (fresh)
				ticks_left = ticks_left + START_DELAY;
		end
	endfunction

	function void apply_word(in_item_t w);
		out_item_t r;
		r = '0;
		case (w.op)
			OP_TICK: begin
				if (running) begin
					if (cascade) begin
						if (w.chain_in)
							r.overflow_out = count_up();
					end else if (ticks_left > 1) begin
						ticks_left = ticks_left - 1'b1;
					end else begin
						ticks_left = period(ps);
						r.overflow_out = count_up();
					end
				end
				phase = phase + 1'b1;
			end
			OP_READ: begin
				case (w.reg_sel)
					SEL_LOW:  r.rdata = count[7:0];
					SEL_HIGH: r.rdata = count[15:8];
					SEL_CTRL: r.rdata = {running, irq_en, 3'b000, cascade, ps};
					default:  r.rdata = 8'h00;
				endcase
			end
			OP_WRITE: begin
				case (w.reg_sel)
					SEL_LOW:  reload[7:0] = w.wdata;
					SEL_HIGH: reload[15:8] = w.wdata;
					SEL_CTRL: write_control(w.wdata);
					default:  ;
				endcase
			end
			default: ;
		endcase
		r.irq = r.overflow_out & irq_en;
		due_words.push_back(r);
	endfunction

	function void note_mismatch(string what);
		mismatches++;
		if (mismatches <= 100)
			$display("MISMATCH at %0t: %s", $time, what);
	endfunction

	function void compare_word(out_item_t got);
		out_item_t want;
		if (due_words.size() == 0) begin
			note_mismatch($sformatf("unexpected word %h", got));
			return;
		end
		want = due_words.pop_front();
		if (got.rdata !== want.rdata)
			note_mismatch($sformatf("rdata %h, want %h", got.rdata, want.rdata));
		if (got.overflow_out !== want.overflow_out)
			note_mismatch($sformatf("overflow_out %b, want %b", got.overflow_out,
				want.overflow_out));
		if (got.irq !== want.irq)
			note_mismatch($sformatf("irq %b, want %b", got.irq, want.irq));
	endfunction

	function int pending();
		return due_words.size();
	endfunction
endclass

module cascadable_prescaled_reload_timer_test;
	localparam int QUIET_LIMIT = 5000;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic [1:0] SEL_NONE = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_data = 2'd0;

	bit          no_gaps = 1'b0;
	int          quiet = 0;
	int          words_sent = 0;
	timer_mirror mirror = new();

	cascadable_prescaled_reload_timer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function int gap_pct();
		return no_gaps ? 0 : 33;
	endfunction

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= gap_pct());
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			mirror.apply_word(in_data);
		if (out_valid && out_ready)
			mirror.compare_word(out_data);
		if (cfg_valid && cfg_ready)
			mirror.chain_pos = cfg_data;
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet = quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// all tasks are entered and left at a falling edge
	task automatic wait_drained();
		while (mirror.pending() != 0)
			@(negedge clk);
	endtask

	task automatic send_word(logic [1:0] op, logic [1:0] sel, logic [7:0] data, bit chain);
		in_item_t w;
		w.op = op;
		w.reg_sel = sel;
		w.wdata = data;
		w.chain_in = chain;
		if ($urandom_range(0, 99) == 0) begin
			in_valid <= 1'b0;
			@(negedge clk);
			wait_drained();
		end
		while ($urandom_range(0, 99) < gap_pct()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (op == OP_TICK || op == OP_READ || op == OP_WRITE)
			words_sent++;
	endtask

	task automatic set_position(logic [1:0] pos);
		in_valid <= 1'b0;
		@(negedge clk);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= pos;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		send_word(OP_READ, SEL_LOW, 8'hFF, 1'b1);
		send_word(OP_READ, SEL_HIGH, 8'h00, 1'b0);
		send_word(OP_READ, SEL_CTRL, 8'h00, 1'b0);
		send_word(OP_READ, SEL_NONE, 8'hFF, 1'b1);
		send_word(OP_WRITE, SEL_LOW, 8'hFF, 1'b0);
		send_word(OP_WRITE, SEL_HIGH, 8'hFF, 1'b0);
		send_word(OP_WRITE, SEL_NONE, 8'h00, 1'b1);
		send_word(OP_NONE, SEL_NONE, 8'hFF, 1'b1);
		// run, irq, divide by one: wraps on every tick once the start delay is over
		send_word(OP_WRITE, SEL_CTRL, 8'hC0, 1'b0);
		send_word(OP_TICK, SEL_LOW, 8'h00, 1'b0);
		send_word(OP_READ, SEL_LOW, 8'h00, 1'b0);
		repeat (4) send_word(OP_TICK, SEL_LOW, 8'h00, 1'b1);
		send_word(OP_READ, SEL_CTRL, 8'h00, 1'b0);
		// everything set: cascade, divide by 1024
		send_word(OP_WRITE, SEL_CTRL, 8'hFF, 1'b0);
		send_word(OP_TICK, SEL_LOW, 8'h00, 1'b0);
		send_word(OP_TICK, SEL_LOW, 8'h00, 1'b1);
		send_word(OP_TICK, SEL_HIGH, 8'hFF, 1'b1);
		send_word(OP_WRITE, SEL_CTRL, 8'h00, 1'b1);
		send_word(OP_WRITE, SEL_LOW, 8'h00, 1'b0);
		send_word(OP_WRITE, SEL_CTRL, 8'h81, 1'b0);
		send_word(OP_READ, SEL_HIGH, 8'h00, 1'b0);
		send_word(OP_WRITE, SEL_CTRL, 8'h38, 1'b0);
	endtask

	// mostly reload/control programs followed by tick bursts; some noise words
	task automatic run_random(int until_count);
		int roll;
		int burst;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] ctrl;
		while (words_sent < until_count) begin
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				send_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 8'($urandom),
					1'($urandom_range(0, 1)));
			end else begin
				if (roll < 70) begin
					lo = $urandom_range(0, 1) ? 8'($urandom_range(248, 255)) : 8'($urandom);
					hi = ($urandom_range(0, 9) < 7) ? 8'hFF : 8'($urandom);
					send_word(OP_WRITE, SEL_LOW, lo, 1'($urandom_range(0, 1)));
					send_word(OP_WRITE, SEL_HIGH, hi, 1'($urandom_range(0, 1)));
				end
				ctrl = 8'($urandom);
				ctrl[7] = ($urandom_range(0, 99) < 85);
				if ($urandom_range(0, 1))
					ctrl[1:0] = PS_DIV1;
				send_word(OP_WRITE, SEL_CTRL, ctrl, 1'($urandom_range(0, 1)));
				burst = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 40);
				repeat (burst) begin
					if ($urandom_range(0, 9) == 0)
						send_word(OP_READ, 2'($urandom_range(0, 3)), 8'($urandom),
							1'($urandom_range(0, 1)));
					else
						send_word(OP_TICK, 2'($urandom), 8'($urandom),
							1'($urandom_range(0, 1)));
				end
			end
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_position(2'd3);
		run_directed();
		run_random(300);
		set_position(2'd0);
		run_random(600);
		set_position(2'd1);
		no_gaps = 1'b1;
		run_random(800);
		no_gaps = 1'b0;
		run_random(950);
		set_position(2'd2);
		run_random(1250);
		set_position(2'd3);
		run_random(1550);
		in_valid <= 1'b0;
		@(negedge clk);
		wait_drained();
		repeat (10) @(posedge clk);
		if (mirror.pending() != 0)
			mirror.note_mismatch($sformatf("%0d words never arrived", mirror.pending()));
		if (mirror.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

@@ sim.f @@
hw/rtl/cprt_pkg.sv
hw/rtl/cprt_core.sv
hw/rtl/cascadable_prescaled_reload_timer.sv
verif/cascadable_prescaled_reload_timer_test.sv
